FILE: hdl/mhpq_pkg.sv
// Shared types, constants and command/status structs for the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    // Default number of heap store words; entry 0 is never used
    localparam int DEF_STORE_DEPTH = 128;

    // Fixed field widths
    localparam int KEY_W         = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 40;

    // Operation carried in the request's tuser bit
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    start_ins;
        logic    start_del;
        logic    take_last;
        logic    up_read;
        logic    up_step;
        logic    dn_read;
        logic    dn_step;
        logic    put_key;
        logic    load_status;
        status_t status_code;
        logic    load_out;
    } hq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_move;
        logic dn_move;
    } hq_stat_t;

endpackage

FILE: hdl/mhpq_ctrl.sv
// Controller state machine sequencing insert and delete sifts over the heap store.
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              req_mode,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mhpq_pkg::hq_stat_t stat,
    output mhpq_pkg::hq_cmd_t  cmd
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    // Decode state and datapath status into commands and the next state
    always_comb begin
        cmd          = '0;
        cmd.status_code = STATUS_OK;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_status = 1'b1;
                    if (req_mode == MODE_INSERT) begin
                        if (stat.full) begin
                            cmd.status_code = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            cmd.start_ins = 1'b1;
                            state_next    = ST_UP_RD;
                        end
                    end else begin
                        if (stat.empty) begin
                            cmd.status_code = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end else begin
                            cmd.start_del = 1'b1;
                            state_next    = ST_DN_LAST;
                        end
                    end
                end
            end
            ST_UP_RD: begin
                if (stat.at_root) begin
                    cmd.put_key = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.up_read = 1'b1;
                    state_next  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_move) begin
                    cmd.up_step = 1'b1;
                    state_next  = ST_UP_RD;
                end else begin
                    cmd.put_key = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DN_LAST: begin
                cmd.take_last = 1'b1;
                state_next    = ST_DN_RD;
            end
            ST_DN_RD: begin
                cmd.dn_read = 1'b1;
                state_next  = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (stat.dn_move) begin
                    cmd.dn_step = 1'b1;
                    state_next  = ST_DN_RD;
                end else begin
                    cmd.put_key = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hdl/mhpq_datapath.sv
// Heap store memory, moving key, position and count registers, and the result register.
`timescale 1ns / 1ps

module mhpq_datapath #(
    parameter int STORE_DEPTH = mhpq_pkg::DEF_STORE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mhpq_pkg::hq_cmd_t                   cmd,
    output mhpq_pkg::hq_stat_t                  stat,
    input  mhpq_pkg::key_t                      req_value,
    output mhpq_pkg::key_t                      out_top,
    output logic [mhpq_pkg::ENTRY_COUNT_W-1:0]  out_count,
    output mhpq_pkg::status_t                   out_status
);
    import mhpq_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH);

    // Heap store: one write port, two registered read ports
    key_t            mem [STORE_DEPTH];
    key_t            rd0_reg, rd1_reg;
    logic [CW-1:0]   raddr0, raddr1;
    logic            we;
    logic [CW-1:0]   waddr;
    key_t            wdata;

    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    key_t            key_reg, key_next;
    key_t            top_reg;
    status_t         status_reg;
    key_t            out_top_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    status_t         out_status_reg;

    logic [CW-1:0]   parent;
    logic [CW:0]     child_l, child_r;
    logic            l_ok, r_ok, go_l, go_r;
    key_t            best_val, child_val;
    logic [CW:0]     child_idx;

    // Tree navigation
    assign parent  = pos_reg >> 1;
    assign child_l = {pos_reg, 1'b0};
    assign child_r = {pos_reg, 1'b1};
    assign l_ok    = child_l <= {1'b0, count_reg};
    assign r_ok    = child_r <= {1'b0, count_reg};

    // Pick the larger child that beats the moving key; left wins ties
    assign go_l      = l_ok && (key_reg < rd0_reg);
    assign best_val  = go_l ? rd0_reg : key_reg;
    assign go_r      = r_ok && (best_val < rd1_reg);
    assign child_val = go_r ? rd1_reg : rd0_reg;
    assign child_idx = go_r ? child_r : child_l;

    assign stat.full    = (count_reg == CW'(STORE_DEPTH - 1));
    assign stat.empty   = (count_reg == '0);
    assign stat.at_root = (pos_reg == CW'(1));
    assign stat.up_move = (rd0_reg < key_reg);
    assign stat.dn_move = go_l || go_r;

    // Select read addresses
    always_comb begin
        if (cmd.up_read) begin
            raddr0 = parent;
        end else if (cmd.dn_read) begin
            raddr0 = child_l[CW-1:0];
        end else begin
            raddr0 = count_reg;
        end
        raddr1 = child_r[CW-1:0];
    end

    // Select the write
    always_comb begin
        we    = cmd.up_step || cmd.dn_step || cmd.put_key;
        waddr = pos_reg;
        if (cmd.up_step) begin
            wdata = rd0_reg;
        end else if (cmd.dn_step) begin
            wdata = child_val;
        end else begin
            wdata = key_reg;
        end
    end

    // Advance position, key and count
    always_comb begin
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        if (cmd.start_ins) begin
            count_next = count_reg + CW'(1);
            pos_next   = count_reg + CW'(1);
            key_next   = req_value;
        end
        if (cmd.start_del) begin
            count_next = count_reg - CW'(1);
            pos_next   = CW'(1);
        end
        if (cmd.take_last) begin
            key_next = rd0_reg;
        end
        if (cmd.up_step) begin
            pos_next = parent;
        end
        if (cmd.dn_step) begin
            pos_next = child_idx[CW-1:0];
        end
    end

    // Memory access
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    // Count is control state; the rest is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Track the root copy, the pending status and the result
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        if (we && (waddr == CW'(1))) begin
            top_reg <= wdata;
        end
        if (cmd.load_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.load_out) begin
            out_top_reg    <= (count_reg == '0) ? key_t'(0) : top_reg;
            out_count_reg  <= ENTRY_COUNT_W'(count_reg);
            out_status_reg <= status_reg;
        end
    end

    assign out_top    = out_top_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;

    // Count stays within capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STORE_DEPTH - 1))
        else $error("heap count beyond capacity");

    // An insert never starts on a full heap
    a_ins_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_ins |-> !stat.full)
        else $error("insert started on full heap");

    // A delete never starts on an empty heap
    a_del_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_del |-> !stat.empty)
        else $error("delete started on empty heap");

    // At most one write source per cycle
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.up_step, cmd.dn_step, cmd.put_key}))
        else $error("conflicting heap writes");

    // An insert grows the count by one
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert count step wrong");

endmodule

FILE: hdl/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue with stream request and result channels.
`timescale 1ns / 1ps

// Each request either inserts a signed key (tuser 0) or deletes the maximum (tuser 1) and gives
// exactly one result: the new top key (zero when empty), the entry count and a status in tuser
// (0 ok, 1 delete on empty heap, 2 insert on full heap dropped). The heap holds up to
// STORE_DEPTH-1 keys in a two-read, one-write memory; one request is worked at a time.
// An insert climbs one level per registered memory read and compare, then writes its key in
// place; a delete first takes the last key, then sinks it one level per registered memory read
// and compare toward the larger child before writing it in place. A key moves at most
// log2(STORE_DEPTH)-1 levels, so the longest request is a delete that sinks to the bottom.
// After each result the block returns to idle before the next request is taken. Rejected
// requests go straight to their result. A finished result sits in an output register, and
// the next request is taken while it waits. The store needs no clearing pass after reset.
module max_heap_priority_queue #(
    parameter int STORE_DEPTH = mhpq_pkg::DEF_STORE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mhpq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [0:0]                      s_tuser,   // [0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] top_value, [38:32] entry_count
    output logic [mhpq_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
    import mhpq_pkg::*;

    hq_cmd_t                  cmd;
    hq_stat_t                 stat;
    key_t                     out_top;
    logic [ENTRY_COUNT_W-1:0] out_count;
    status_t                  out_status;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_mode (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .req_value  (key_t'(s_tdata)),
        .out_top    (out_top),
        .out_count  (out_count),
        .out_status (out_status)
    );

    // Pack the result
    assign m_tdata = {1'b0, out_count, out_top};
    assign m_tuser = out_status;

endmodule

FILE: dv/max_heap_priority_queue_test.sv
// Self-checking stream testbench for the max-heap priority queue: directed and random requests.
`timescale 1ns / 1ps

module max_heap_priority_queue_test;
    import mhpq_pkg::*;

    localparam int DEPTH        = DEF_STORE_DEPTH;
    localparam int CAPACITY     = DEPTH - 1;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct {
        key_t                     top_value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        status_t                  status;
    } heap_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] value
    logic [0:0]           s_tuser  = '0;   // [0] mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] top_value, [38:32] entry_count
    logic [STATUS_W-1:0]  m_tuser;         // [1:0] status

    // Shadow heap: keys from index 1, and the number held
    key_t         model_keys [DEPTH];
    int           model_count = 0;
    heap_result_t awaited_results [$];

    int mismatches    = 0;
    int requests_sent = 0;
    bit gaps_on       = 1'b1;
    int hold_cycles   = 0;

    max_heap_priority_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // Abandon a hung run
    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix full-range keys with narrow ranges that force ties and with corner values
    function automatic key_t pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return key_t'($urandom());
            4, 5:       return key_t'($urandom_range(0, 6)) - 3;
            6: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:    return key_t'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Apply one request to the shadow heap and return the result it should give
    function automatic heap_result_t apply_heap_op(input logic mode, input key_t key);
        heap_result_t res;
        int           pos;
        int           child;
        int           best;
        key_t         held;
        res.status = STATUS_OK;
        if (mode == MODE_INSERT) begin
            if (model_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                // append, then climb while the parent is smaller
                model_count++;
                pos = model_count;
                model_keys[pos] = key;
                while (pos > 1 && model_keys[pos / 2] < model_keys[pos]) begin
                    held                = model_keys[pos / 2];
                    model_keys[pos / 2] = model_keys[pos];
                    model_keys[pos]     = held;
                    pos                 = pos / 2;
                end
            end
        end else if (model_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            // move the last key to the root and sink it toward the larger child, left on a tie
            model_keys[1] = model_keys[model_count];
            model_count--;
            pos  = 0;
            best = 1;
            while (best != pos) begin
                pos   = best;
                child = 2 * pos;
                if (child <= model_count && model_keys[best] < model_keys[child])
                    best = child;
                if (child + 1 <= model_count && model_keys[best] < model_keys[child + 1])
                    best = child + 1;
                if (best != pos) begin
                    held             = model_keys[best];
                    model_keys[best] = model_keys[pos];
                    model_keys[pos]  = held;
                end
            end
        end
        res.top_value   = (model_count > 0) ? model_keys[1] : key_t'(0);
        res.entry_count = model_count[ENTRY_COUNT_W-1:0];
        return res;
    endfunction

    // Offer one request after an optional gap and hold it until taken
    task automatic send_request(input logic mode, input key_t key);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        awaited_results.push_back(apply_heap_op(mode, key));
        requests_sent++;
    endtask

    // Result side: random stalls, plus a long hold when a test asks for one
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each delivered result with the oldest one awaited
    always @(posedge aclk) begin : result_check
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: top_value %0d", $signed(m_tdata[31:0]));
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if ($signed(m_tdata[31:0]) !== want.top_value) begin
                    $error("top_value: expected %0d, got %0d",
                           want.top_value, $signed(m_tdata[31:0]));
                    mismatches++;
                end
                if (m_tdata[38:32] !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_tdata[38:32]);
                    mismatches++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_delete_on_empty();
        send_request(MODE_DELETE, pick_key());
        send_request(MODE_DELETE, '0);
    endtask

    task automatic test_key_extremes();
        send_request(MODE_INSERT, 32'sh8000_0000);
        send_request(MODE_INSERT, 32'sh7fff_ffff);
        send_request(MODE_INSERT, '0);
        send_request(MODE_INSERT, '1);
        repeat (5) send_request(MODE_DELETE, '1);
    endtask

    // Duplicates make both children equal during a sink
    task automatic test_equal_keys();
        send_request(MODE_INSERT, 32'sd7);
        send_request(MODE_INSERT, 32'sd7);
        send_request(MODE_INSERT, 32'sd7);
        send_request(MODE_INSERT, 32'sd3);
        send_request(MODE_INSERT, 32'sd7);
        send_request(MODE_INSERT, 32'sd7);
        repeat (7) send_request(MODE_DELETE, pick_key());
    endtask

    // Fill to capacity, push past it, then drain past empty
    task automatic test_full_heap();
        while (model_count < CAPACITY) send_request(MODE_INSERT, pick_key());
        send_request(MODE_INSERT, 32'sh7fff_ffff);
        send_request(MODE_INSERT, pick_key());
        while (model_count > 0) send_request(MODE_DELETE, pick_key());
        send_request(MODE_DELETE, pick_key());
    endtask

    // Hold off the result side while requests keep coming back to back
    task automatic test_output_stall();
        gaps_on     = 1'b0;
        hold_cycles = 80;
        repeat (12) send_request(MODE_INSERT, pick_key());
        repeat (12) send_request(MODE_DELETE, pick_key());
        gaps_on = 1'b1;
    endtask

    // Phases leaning toward inserts, deletes or neither, so the heap swings between
    // empty and full
    task automatic test_random_mix();
        int first;
        int bias;
        int run_len;
        first = requests_sent;
        while (requests_sent - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       bias = 90;
                1:       bias = 50;
                default: bias = 15;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            run_len = $urandom_range(20, 200);
            repeat (run_len)
                send_request(($urandom_range(0, 99) < bias) ? MODE_INSERT : MODE_DELETE,
                             pick_key());
        end
        gaps_on = 1'b1;
    endtask

    initial begin : run_tests
        int waited;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_delete_on_empty();
        test_key_extremes();
        test_equal_keys();
        test_full_heap();
        test_output_stall();
        test_random_mix();

        // Drain outstanding results, then allow for the block's latency
        s_tvalid <= 1'b0;
        gaps_on = 1'b0;
        waited  = 0;
        while (awaited_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            mismatches++;
        end
        repeat (20) @(posedge aclk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
